// ----- rtl/mthd_pkg.sv -----
`default_nettype none
// ============================================================================
// mthd_pkg
// Shared constants, types and helpers for the median threshold hit detector.
// ============================================================================
package mthd_pkg;

    localparam int CHANNEL_COUNT     = 10;
    localparam int CHAN_W            = $clog2(CHANNEL_COUNT);
    localparam int RANK_W            = $clog2(CHANNEL_COUNT + 1);
    localparam int MEDIAN_RANK       = CHANNEL_COUNT / 2 - 1;
    localparam int FACTOR_W          = 10;
    localparam int OUT_COUNT_W       = 16;
    localparam int DEF_POWER_WIDTH   = 32;
    localparam int DEF_COUNT_WIDTH   = 16;

    localparam int APB_ADDR_W        = 4;
    localparam int APB_DATA_W        = 32;
    localparam int REG_IDX_W         = 2;

    localparam logic [CHAN_W-1:0]    DEFAULT_WINNER = CHAN_W'(2);

    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_INDEX = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_IGNORE_MASK     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_IGNORE_ALL      = 2'd2;

    localparam logic [1:0] THR_X10   = 2'd0;
    localparam logic [1:0] THR_X100  = 2'd1;
    localparam logic [1:0] THR_X1000 = 2'd2;

    localparam logic KIND_EVAL  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef struct packed {
        logic [1:0]               threshold_index;
        logic [CHANNEL_COUNT-1:0] ignore_mask;
        logic                     ignore_all;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{threshold_index: THR_X1000,
                                   ignore_mask:     '0,
                                   ignore_all:      1'b0};

    function automatic logic [FACTOR_W-1:0] ratio_factor(input logic [1:0] idx);
        logic [FACTOR_W-1:0] f;
        case (idx)
            THR_X10:  f = FACTOR_W'(10);
            THR_X100: f = FACTOR_W'(100);
            default:  f = FACTOR_W'(1000);
        endcase
        return f;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/median_threshold_hit_detector_top.sv -----
`default_nettype none
// ============================================================================
// median_threshold_hit_detector_top
// Ten-channel median-relative threshold hit detector with APB registers.
// ============================================================================
// Takes one beat per clock while the output is not stalled and returns one
// result beat per input beat, in order. Stages: input register, ten ranking
// lanes plus merge (max, upper median, hit channel), median times factor
// multiply, hit decision and counter update. Counters are read and updated in
// the same stage, so consecutive hits on one channel need no spacing. Each
// stage holds its beat only while the next is full, so input is taken while a
// result waits at the output.
module median_threshold_hit_detector_top
    import mthd_pkg::*;
#(
    parameter int POWER_WIDTH = DEF_POWER_WIDTH,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready,

    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   kind,
    input  wire logic                   lockout_active,
    input  wire logic [POWER_WIDTH-1:0] power_0,
    input  wire logic [POWER_WIDTH-1:0] power_1,
    input  wire logic [POWER_WIDTH-1:0] power_2,
    input  wire logic [POWER_WIDTH-1:0] power_3,
    input  wire logic [POWER_WIDTH-1:0] power_4,
    input  wire logic [POWER_WIDTH-1:0] power_5,
    input  wire logic [POWER_WIDTH-1:0] power_6,
    input  wire logic [POWER_WIDTH-1:0] power_7,
    input  wire logic [POWER_WIDTH-1:0] power_8,
    input  wire logic [POWER_WIDTH-1:0] power_9,

    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        hit_now,
    output logic                        hit_pending,
    output logic [CHAN_W-1:0]           last_channel,
    output logic [OUT_COUNT_W-1:0]      last_channel_count
);

    localparam int PROD_W = POWER_WIDTH + FACTOR_W;

    cfg_t                   cfg_reg;
    logic                   cfg_write;
    logic [REG_IDX_W-1:0]   reg_idx;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_THRESHOLD_INDEX: cfg_reg.threshold_index <= pwdata[1:0];
                REG_IGNORE_MASK:     cfg_reg.ignore_mask     <= pwdata[CHANNEL_COUNT-1:0];
                REG_IGNORE_ALL:      cfg_reg.ignore_all      <= pwdata[0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_THRESHOLD_INDEX: prdata = APB_DATA_W'(cfg_reg.threshold_index);
            REG_IGNORE_MASK:     prdata = APB_DATA_W'(cfg_reg.ignore_mask);
            REG_IGNORE_ALL:      prdata = APB_DATA_W'(cfg_reg.ignore_all);
            default:             prdata = '0;
        endcase
    end

    // ---- pipeline control ----
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !out_valid_reg || !out_stall;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                out_valid_reg <= v3_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // ---- stage 1: input register ----
    logic [CHANNEL_COUNT-1:0][POWER_WIDTH-1:0] pw_in;
    logic [CHANNEL_COUNT-1:0][POWER_WIDTH-1:0] pw1_reg;
    logic                                      kind1_reg, lock1_reg;

    assign pw_in = {power_9, power_8, power_7, power_6, power_5,
                    power_4, power_3, power_2, power_1, power_0};

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            pw1_reg   <= pw_in;
            kind1_reg <= kind;
            lock1_reg <= lockout_active;
        end
    end

    // ---- stage 2: lanes and merge ----
    logic [CHANNEL_COUNT-1:0] lane_max;
    logic [CHANNEL_COUNT-1:0] lane_med;
    logic [POWER_WIDTH-1:0]   max_c, med_c;
    logic [CHAN_W-1:0]        win_c;

    for (genvar g = 0; g < CHANNEL_COUNT; g++)
    begin : g_lane
        mthd_lane #(.POWER_WIDTH(POWER_WIDTH)) u_lane
        (
            .own_power (pw1_reg[g]),
            .all_power (pw1_reg),
            .is_max    (lane_max[g]),
            .is_med    (lane_med[g])
        );
    end

    mthd_merge #(.POWER_WIDTH(POWER_WIDTH)) u_merge
    (
        .all_power (pw1_reg),
        .lane_max  (lane_max),
        .lane_med  (lane_med),
        .max_power (max_c),
        .med_power (med_c),
        .winner    (win_c)
    );

    logic [POWER_WIDTH-1:0] max2_reg, med2_reg;
    logic [CHAN_W-1:0]      win2_reg;
    logic                   kind2_reg, lock2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            max2_reg  <= max_c;
            med2_reg  <= med_c;
            win2_reg  <= win_c;
            kind2_reg <= kind1_reg;
            lock2_reg <= lock1_reg;
        end
    end

    // ---- stage 3: median times factor ----
    logic [PROD_W-1:0]      limit_c;
    logic [PROD_W-1:0]      limit3_reg;
    logic [POWER_WIDTH-1:0] max3_reg;
    logic [CHAN_W-1:0]      win3_reg;
    logic                   kind3_reg, lock3_reg;

    assign limit_c = PROD_W'(med2_reg) * PROD_W'(ratio_factor(cfg_reg.threshold_index));

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            limit3_reg <= limit_c;
            max3_reg   <= max2_reg;
            win3_reg   <= win2_reg;
            kind3_reg  <= kind2_reg;
            lock3_reg  <= lock2_reg;
        end
    end

    // ---- stage 4: hit decision and state ----
    mthd_tracker #(.POWER_WIDTH(POWER_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) u_tracker
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .load               (rdy4 && v3_reg),
        .kind               (kind3_reg),
        .lockout_active     (lock3_reg),
        .max_power          (max3_reg),
        .limit              (limit3_reg),
        .winner             (win3_reg),
        .cfg                (cfg_reg),
        .hit_now            (hit_now),
        .hit_pending        (hit_pending),
        .last_channel       (last_channel),
        .last_channel_count (last_channel_count)
    );

endmodule
`default_nettype wire

// ----- rtl/mthd_lane.sv -----
`default_nettype none
// ============================================================================
// mthd_lane
// One channel lane: ranks its own power against every channel of the beat.
// ============================================================================
module mthd_lane
    import mthd_pkg::*;
#(
    parameter int POWER_WIDTH = DEF_POWER_WIDTH
)
(
    input  wire logic [POWER_WIDTH-1:0]                    own_power,
    input  wire logic [CHANNEL_COUNT-1:0][POWER_WIDTH-1:0] all_power,
    output logic                                           is_max,
    output logic                                           is_med
);

    logic [CHANNEL_COUNT-1:0] above;
    logic [CHANNEL_COUNT-1:0] at_or_above;
    logic [RANK_W-1:0]        gt_cnt;
    logic [RANK_W-1:0]        ge_cnt;

    always_comb
    begin
        gt_cnt = '0;
        ge_cnt = '0;
        for (int j = 0; j < CHANNEL_COUNT; j++)
        begin
            above[j]       = all_power[j] > own_power;
            at_or_above[j] = !(own_power > all_power[j]);
            gt_cnt         = gt_cnt + RANK_W'(above[j]);
            ge_cnt         = ge_cnt + RANK_W'(at_or_above[j]);
        end
    end

    // sorted descending, this value covers positions gt_cnt .. ge_cnt-1
    assign is_max = (gt_cnt == '0);
    assign is_med = (gt_cnt <= RANK_W'(MEDIAN_RANK)) && (ge_cnt > RANK_W'(MEDIAN_RANK));

endmodule
`default_nettype wire

// ----- rtl/mthd_merge.sv -----
`default_nettype none
// ============================================================================
// mthd_merge
// Combines lane flags into the maximum, the upper median and the hit channel.
// ============================================================================
module mthd_merge
    import mthd_pkg::*;
#(
    parameter int POWER_WIDTH = DEF_POWER_WIDTH
)
(
    input  wire logic [CHANNEL_COUNT-1:0][POWER_WIDTH-1:0] all_power,
    input  wire logic [CHANNEL_COUNT-1:0]                  lane_max,
    input  wire logic [CHANNEL_COUNT-1:0]                  lane_med,
    output logic [POWER_WIDTH-1:0]                         max_power,
    output logic [POWER_WIDTH-1:0]                         med_power,
    output logic [CHAN_W-1:0]                              winner
);

    always_comb
    begin
        max_power = '0;
        med_power = '0;
        winner    = DEFAULT_WINNER;
        for (int c = 0; c < CHANNEL_COUNT; c++)
        begin
            max_power = max_power | (all_power[c] & {POWER_WIDTH{lane_max[c]}});
            med_power = med_power | (all_power[c] & {POWER_WIDTH{lane_med[c]}});
        end
        if (!lane_max[DEFAULT_WINNER])
        begin
            for (int c = CHANNEL_COUNT - 1; c >= 0; c--)
            begin
                if (lane_max[c])
                    winner = CHAN_W'(c);
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/mthd_tracker.sv -----
`default_nettype none
// ============================================================================
// mthd_tracker
// Hit decision, per-channel hit counters, sticky flag and last hit channel.
// ============================================================================
module mthd_tracker
    import mthd_pkg::*;
#(
    parameter int POWER_WIDTH = DEF_POWER_WIDTH,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            load,
    input  wire logic                            kind,
    input  wire logic                            lockout_active,
    input  wire logic [POWER_WIDTH-1:0]          max_power,
    input  wire logic [POWER_WIDTH+FACTOR_W-1:0] limit,
    input  wire logic [CHAN_W-1:0]               winner,
    input  wire cfg_t                            cfg,
    output logic                                 hit_now,
    output logic                                 hit_pending,
    output logic [CHAN_W-1:0]                    last_channel,
    output logic [OUT_COUNT_W-1:0]               last_channel_count
);

    localparam int PROD_W = POWER_WIDTH + FACTOR_W;
    localparam int EXT_W  = (COUNT_WIDTH > OUT_COUNT_W) ? COUNT_WIDTH : OUT_COUNT_W;

    logic [COUNT_WIDTH-1:0] counts_reg [CHANNEL_COUNT];
    logic [COUNT_WIDTH-1:0] cur_count_reg;
    logic [COUNT_WIDTH-1:0] inc_count;
    logic                   hit_now_reg;
    logic                   pending_reg;
    logic [CHAN_W-1:0]      recent_reg;
    logic                   hit;
    logic                   pending_next;
    logic [EXT_W-1:0]       count_ext;

    assign hit = (kind == KIND_EVAL) && !lockout_active && !cfg.ignore_all
                 && (PROD_W'(max_power) > limit) && !cfg.ignore_mask[winner];

    assign inc_count = counts_reg[winner] + COUNT_WIDTH'(1);

    always_comb
    begin
        pending_next = pending_reg;
        if (kind == KIND_CLEAR)
            pending_next = 1'b0;
        else if (hit)
            pending_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNEL_COUNT; c++)
                counts_reg[c] <= '0;
            cur_count_reg <= '0;
            hit_now_reg   <= 1'b0;
            pending_reg   <= 1'b0;
            recent_reg    <= '0;
        end
        else if (load)
        begin
            hit_now_reg <= hit;
            pending_reg <= pending_next;
            if (hit)
            begin
                counts_reg[winner] <= inc_count;
                cur_count_reg      <= inc_count;
                recent_reg         <= winner;
            end
        end
    end

    assign count_ext          = EXT_W'(cur_count_reg);
    assign hit_now            = hit_now_reg;
    assign hit_pending        = pending_reg;
    assign last_channel       = recent_reg;
    assign last_channel_count = count_ext[OUT_COUNT_W-1:0];

endmodule
`default_nettype wire

// ----- sim/median_threshold_hit_detector_top_tb.sv -----
// ----------------------------------------------------------------------------
// median_threshold_hit_detector_top_tb
// Self-checking bench for the median threshold hit detector. A clocked driver
// sends power beats from a queue in random bursts. A clocked monitor stalls on
// its own pattern and checks every result beat against a scoring model. The
// model ranks the ten powers, compares the peak with the upper median times the
// factor, and tracks the hit counters. Register settings change over APB
// between phases, and one phase sends back-to-back hits on a single channel.
// ----------------------------------------------------------------------------
module median_threshold_hit_detector_top_tb;
    import mthd_pkg::*;

    localparam int PW          = DEF_POWER_WIDTH;
    localparam int CYCLE_LIMIT = 100000;
    localparam int SETTLE      = 12;
    localparam int LONG_HOLD   = 400;
    localparam int RUN_BEATS   = 40;
    localparam int PHASE_BEATS = 90;
    localparam logic [1:0] THR_SAT = 2'd3;

    typedef struct packed {
        logic                             kind;
        logic                             lockout;
        logic [CHANNEL_COUNT-1:0][PW-1:0] pw;
    } power_beat_t;

    typedef struct packed {
        logic                   hit_now;
        logic                   hit_pending;
        logic [CHAN_W-1:0]      chan;
        logic [OUT_COUNT_W-1:0] count;
    } hit_result_t;

    logic                   clk;
    logic                   rst_n          = 1'b0;
    logic                   psel           = 1'b0;
    logic                   penable        = 1'b0;
    logic                   pwrite         = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr          = '0;
    logic [APB_DATA_W-1:0]  pwdata         = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   in_valid       = 1'b0;
    logic                   in_stall;
    logic                   kind           = KIND_EVAL;
    logic                   lockout_active = 1'b0;
    logic [PW-1:0]          power_0 = '0, power_1 = '0, power_2 = '0, power_3 = '0;
    logic [PW-1:0]          power_4 = '0, power_5 = '0, power_6 = '0, power_7 = '0;
    logic [PW-1:0]          power_8 = '0, power_9 = '0;
    logic                   out_valid;
    logic                   out_stall      = 1'b0;
    logic                   hit_now;
    logic                   hit_pending;
    logic [CHAN_W-1:0]      last_channel;
    logic [OUT_COUNT_W-1:0] last_channel_count;

    median_threshold_hit_detector_top dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .kind               (kind),
        .lockout_active     (lockout_active),
        .power_0            (power_0),
        .power_1            (power_1),
        .power_2            (power_2),
        .power_3            (power_3),
        .power_4            (power_4),
        .power_5            (power_5),
        .power_6            (power_6),
        .power_7            (power_7),
        .power_8            (power_8),
        .power_9            (power_9),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .hit_now            (hit_now),
        .hit_pending        (hit_pending),
        .last_channel       (last_channel),
        .last_channel_count (last_channel_count)
    );

    // scoring state and register copies
    logic [1:0]                 thr_q  = THR_X1000;
    logic [CHANNEL_COUNT-1:0]   mask_q = '0;
    logic                       all_q  = 1'b0;
    logic [OUT_COUNT_W-1:0]     hit_cnt [CHANNEL_COUNT];
    logic                       sticky_q = 1'b0;
    int                         recent_q = 0;

    power_beat_t power_beats [$];
    hit_result_t pending_results [$];
    power_beat_t cur_beat;

    int unsigned queued = 0, accepted = 0, results = 0;
    int unsigned hit_total = 0, clear_total = 0, reg_writes = 0;
    int unsigned errors = 0, cycles = 0;
    int          burst_left = 0, gap_left = 0;
    logic        no_idle = 1'b0;
    logic        hold_req = 1'b0, hold_seen = 1'b0;
    int          hold_left = 0, mode_left = 0, stall_mode = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        for (int c = 0; c < CHANNEL_COUNT; c++)
            hit_cnt[c] = '0;
    end

    function automatic logic [63:0] mult_for(input logic [1:0] thr);
        case (thr)
            THR_X10:  return 64'd10;
            THR_X100: return 64'd100;
            default:  return 64'd1000;
        endcase
    endfunction

    function automatic hit_result_t score_beat(input power_beat_t b);
        logic [PW-1:0] srt [CHANNEL_COUNT];
        logic [PW-1:0] t;
        logic [63:0]   bar;
        int            win;
        hit_result_t   r;
        r.hit_now = 1'b0;
        if (b.kind == KIND_CLEAR)
        begin
            sticky_q = 1'b0;
            clear_total++;
        end
        else if (!b.lockout)
        begin
            for (int c = 0; c < CHANNEL_COUNT; c++)
                srt[c] = b.pw[c];
            for (int i = 0; i < CHANNEL_COUNT - 1; i++)
                for (int j = i + 1; j < CHANNEL_COUNT; j++)
                    if (srt[i] < srt[j])
                    begin
                        t = srt[i];
                        srt[i] = srt[j];
                        srt[j] = t;
                    end
            bar = 64'(srt[MEDIAN_RANK]) * mult_for(thr_q);
            if (64'(srt[0]) > bar && !all_q)
            begin
                win = int'(DEFAULT_WINNER);
                for (int c = 0; c < CHANNEL_COUNT; c++)
                    if (b.pw[c] > b.pw[win])
                        win = c;
                if (!mask_q[win])
                begin
                    hit_cnt[win] = hit_cnt[win] + 1'b1;
                    sticky_q = 1'b1;
                    recent_q = win;
                    r.hit_now = 1'b1;
                    hit_total++;
                end
            end
        end
        r.hit_pending = sticky_q;
        r.chan = CHAN_W'(recent_q);
        r.count = hit_cnt[recent_q];
        return r;
    endfunction

    function automatic power_beat_t flat_with_spike(input logic k, input logic lock,
                                                    input logic [PW-1:0] level, input int ch,
                                                    input logic [PW-1:0] peak);
        power_beat_t b;
        b.kind = k;
        b.lockout = lock;
        for (int c = 0; c < CHANNEL_COUNT; c++)
            b.pw[c] = level;
        b.pw[ch] = peak;
        return b;
    endfunction

    // mostly beats shaped around the current threshold, plus clears, lockouts and noise
    function automatic power_beat_t random_beat();
        power_beat_t b;
        logic [31:0] lvl;
        logic [63:0] peak;
        int          pick;
        pick = $urandom_range(0, 99);
        b.kind = KIND_EVAL;
        b.lockout = 1'b0;
        lvl = $urandom >> $urandom_range(0, 31);
        for (int c = 0; c < CHANNEL_COUNT; c++)
            b.pw[c] = $urandom_range(0, lvl);
        for (int k = 0; k < 4; k++)
            b.pw[$urandom_range(0, CHANNEL_COUNT - 1)] = lvl;
        peak = 64'(lvl) * mult_for(thr_q);
        case ($urandom_range(0, 3))
            0: if (peak != 0) peak = peak - 1;
            2: peak = peak + 1;
            3: peak = peak + $urandom_range(1, 1000000);
            default: ;
        endcase
        if (peak > 64'hFFFF_FFFF)
            peak = 64'hFFFF_FFFF;
        b.pw[$urandom_range(0, CHANNEL_COUNT - 1)] = peak[31:0];
        if ($urandom_range(0, 4) == 0)
            b.pw[$urandom_range(0, CHANNEL_COUNT - 1)] = peak[31:0];
        if (pick < 12)
        begin
            b.kind = KIND_CLEAR;
            b.lockout = 1'($urandom_range(0, 1));
            for (int c = 0; c < CHANNEL_COUNT; c++)
                b.pw[c] = $urandom;
        end
        else if (pick < 22)
            b.lockout = 1'b1;
        else if (pick < 40)
            for (int c = 0; c < CHANNEL_COUNT; c++)
                b.pw[c] = $urandom;
        return b;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 25)
            $display("MISMATCH at result %0d: %s", results, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic queue_beat(input power_beat_t b);
        power_beats.push_back(b);
        queued++;
    endtask

    task automatic wait_idle();
        while (accepted != queued || pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_THRESHOLD_INDEX: thr_q  = val[1:0];
            REG_IGNORE_MASK:     mask_q = val[CHANNEL_COUNT-1:0];
            REG_IGNORE_ALL:      all_q  = val[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_config(input logic [1:0] thr, input logic [CHANNEL_COUNT-1:0] mask,
                              input logic all);
        wait_idle();
        reg_write(REG_THRESHOLD_INDEX, 32'(thr));
        reg_write(REG_IGNORE_MASK, 32'(mask));
        reg_write(REG_IGNORE_ALL, 32'(all));
    endtask

    // sender: bursts and gaps, beat held while stalled
    always @(posedge clk)
    begin : driver
        logic        nv;
        logic        load;
        power_beat_t nb;
        nv = in_valid;
        load = 1'b0;
        nb = cur_beat;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                pending_results.push_back(score_beat(cur_beat));
                accepted++;
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (gap_left > 0 && !no_idle)
                    gap_left--;
                else if (power_beats.size() > 0)
                begin
                    nb = power_beats.pop_front();
                    nv = 1'b1;
                    load = 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20)
                                                               : $urandom_range(0, 2);
                    end
                end
            end
        end
        in_valid <= nv;
        if (load)
        begin
            cur_beat = nb;
            kind           <= nb.kind;
            lockout_active <= nb.lockout;
            power_0 <= nb.pw[0];
            power_1 <= nb.pw[1];
            power_2 <= nb.pw[2];
            power_3 <= nb.pw[3];
            power_4 <= nb.pw[4];
            power_5 <= nb.pw[5];
            power_6 <= nb.pw[6];
            power_7 <= nb.pw[7];
            power_8 <= nb.pw[8];
            power_9 <= nb.pw[9];
        end
    end

    // receiver: result check plus stall pattern
    always @(posedge clk)
    begin : monitor
        hit_result_t want;
        logic        ns;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                want = pending_results.pop_front();
                check_field("hit_now", 32'(hit_now), 32'(want.hit_now));
                check_field("hit_pending", 32'(hit_pending), 32'(want.hit_pending));
                check_field("last_channel", 32'(last_channel), 32'(want.chan));
                check_field("last_channel_count", 32'(last_channel_count), 32'(want.count));
            end
            results++;
        end
        if (mode_left > 0)
            mode_left--;
        else
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 120);
        end
        if (hold_left > 0)
        begin
            hold_left--;
            ns = 1'b1;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
            ns = 1'b1;
        end
        else if (no_idle)
            ns = 1'b0;
        else
        begin
            case (stall_mode)
                1:       ns = ($urandom_range(0, 3) == 0);
                2:       ns = ($urandom_range(0, 3) != 0);
                3:       ns = ((cycles % 5) < 2);
                default: ns = 1'b0;
            endcase
        end
        out_stall <= ns;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : sequencer
        power_beat_t b;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: factor 1000, nothing masked
        queue_beat(flat_with_spike(KIND_EVAL, 1'b0, '0, 0, '0));
        queue_beat(flat_with_spike(KIND_EVAL, 1'b0, '1, 0, '1));
        queue_beat(flat_with_spike(KIND_EVAL, 1'b0, 32'd1000, 5, 32'd1000000));
        queue_beat(flat_with_spike(KIND_EVAL, 1'b0, 32'd1000, 5, 32'd1000001));
        queue_beat(flat_with_spike(KIND_EVAL, 1'b0, 32'd4294967, 9, '1));
        queue_beat(flat_with_spike(KIND_EVAL, 1'b0, '0, 0, 32'd1));
        queue_beat(flat_with_spike(KIND_EVAL, 1'b1, '0, 7, '1));
        queue_beat(flat_with_spike(KIND_CLEAR, 1'b1, '0, 7, '1));
        b = flat_with_spike(KIND_EVAL, 1'b0, 32'd1, 7, 32'd5000);
        b.pw[2] = 32'd5000;
        queue_beat(b);
        b = flat_with_spike(KIND_EVAL, 1'b0, 32'd1, 8, 32'd5000);
        b.pw[4] = 32'd5000;
        queue_beat(b);
        queue_beat(flat_with_spike(KIND_CLEAR, 1'b0, 32'd1, 3, '1));
        queue_beat(flat_with_spike(KIND_EVAL, 1'b0, 32'd7, 2, '1));

        set_config(THR_X10, '0, 1'b0);
        queue_beat(flat_with_spike(KIND_EVAL, 1'b0, 32'd1, 6, 32'd10));
        queue_beat(flat_with_spike(KIND_EVAL, 1'b0, 32'd1, 6, 32'd11));
        set_config(THR_X100, '0, 1'b0);
        queue_beat(flat_with_spike(KIND_EVAL, 1'b0, 32'd3, 1, 32'd300));
        queue_beat(flat_with_spike(KIND_EVAL, 1'b0, 32'd3, 1, 32'd301));
        set_config(THR_SAT, '0, 1'b0);
        queue_beat(flat_with_spike(KIND_EVAL, 1'b0, 32'd2, 8, 32'd2000));
        queue_beat(flat_with_spike(KIND_EVAL, 1'b0, 32'd2, 8, 32'd2001));
        set_config(THR_X1000, '1, 1'b0);
        queue_beat(flat_with_spike(KIND_EVAL, 1'b0, 32'd1, 5, '1));
        set_config(THR_X1000, 10'h020, 1'b0);
        queue_beat(flat_with_spike(KIND_EVAL, 1'b0, 32'd1, 5, '1));
        queue_beat(flat_with_spike(KIND_EVAL, 1'b0, 32'd1, 6, '1));
        set_config(THR_X1000, '0, 1'b1);
        queue_beat(flat_with_spike(KIND_EVAL, 1'b0, 32'd1, 0, '1));

        // back-to-back hits on channel 3, no idling
        set_config(THR_X1000, '0, 1'b0);
        no_idle <= 1'b1;
        for (int i = 0; i < RUN_BEATS; i++)
            queue_beat(flat_with_spike(KIND_EVAL, 1'b0, 32'd1, 3, '1));
        wait_idle();
        no_idle <= 1'b0;

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_config(THR_X10, '0, 1'b0);
                1: set_config(THR_X100, 10'($urandom) & 10'($urandom), 1'b0);
                2: set_config(THR_SAT, '1, 1'b0);
                3: set_config(THR_X1000, 10'($urandom) & 10'($urandom), 1'b1);
                4: set_config(2'($urandom), 10'($urandom), 1'($urandom));
                default: set_config(THR_X1000, '0, 1'b0);
            endcase
            for (int i = 0; i < PHASE_BEATS; i++)
                queue_beat(random_beat());
            if (ph == 1 || ph == 4)
                hold_req <= ~hold_req;
        end

        wait_idle();
        if (pending_results.size() != 0)
            report_mismatch("expected results left over");
        $display("Checked %0d result beats: %0d hits, %0d clears, %0d register writes",
                 results, hit_total, clear_total, reg_writes);
        $display("Covered all factors, masks, suppression, lockout, ties and repeated hits");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
